### rtl/core/lups_pkg.sv
// shared types, constants and helper functions of the lu pivot linear solver
`default_nettype none
package lups_pkg;

  localparam int unsigned DEF_MAX_ORDER = 8;
  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned DET_W    = 64;
  localparam int unsigned XIDX_W   = 3;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned SIZE_W   = 4;
  localparam int unsigned THR_W    = 31;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
  localparam logic [THR_W-1:0]  THR_RESET  = 31'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_SIZE     = 8'd0,
    REG_PIVOT_THRESHOLD = 8'd1
  } reg_idx_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_SINGULAR = 2'd1,
    STAT_SAT      = 2'd2
  } status_e;

  typedef struct packed {
    logic              sat;
    logic [ELEM_W-1:0] val;
  } sat32_t;

  function automatic sat32_t sat32(input logic signed [63:0] v);
    sat32_t r;
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.val = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [ELEM_W-1:0] abs32(input logic [ELEM_W-1:0] v);
    return v[ELEM_W-1] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/lups_if.sv
// request channels of the lu pivot linear solver: element input, result output, config writes
`default_nettype none
interface lups_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [lups_pkg::ELEM_W-1:0] elem_value;

  modport source (output valid, output elem_value, input ready);
  modport sink   (input valid, input elem_value, output ready);
endinterface

interface lups_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lups_pkg::ELEM_W-1:0]  x_value;
  logic [lups_pkg::XIDX_W-1:0]         x_index;
  logic                               last;
  logic [lups_pkg::STAT_W-1:0]         status;
  logic signed [lups_pkg::DET_W-1:0]   determinant;

  modport source (output valid, output x_value, output x_index, output last,
                  output status, output determinant, input ready);
  modport sink   (input valid, input x_value, input x_index, input last,
                  input status, input determinant, output ready);
endinterface

interface lups_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lups_pkg::CFG_IDX_W-1:0]    index;
  logic [lups_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/lu_pivot_linear_solver_core.sv
// lu pivot linear solver core: loads N*N+N elements at one per cycle, then factors and solves.
// factoring and solving take N*(N+1)/2 divisions in all, on the one-read-port matrix memory
// and the bit-serial divider.
// results leave one at a time, each held until taken; no element is taken until the last is taken.
// reset sets order 8, threshold 1, load count zero and identity row order; stores are not cleared.
`default_nettype none
module lu_pivot_linear_solver_core #(
  parameter int unsigned MAX_ORDER = lups_pkg::DEF_MAX_ORDER,
  parameter int unsigned FRAC_BITS = lups_pkg::DEF_FRAC_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lups_in_if.sink     elem_i,
  lups_cfg_if.sink    cfg_i,
  lups_out_if.source  result_o
);

  localparam int unsigned IW  = $clog2(MAX_ORDER);
  localparam int unsigned NW  = $clog2(MAX_ORDER + 1);
  localparam int unsigned AW  = $clog2(MAX_ORDER * MAX_ORDER);
  localparam int unsigned CW  = $clog2(MAX_ORDER * MAX_ORDER + MAX_ORDER + 1);
  localparam int unsigned QW  = lups_pkg::ELEM_W + FRAC_BITS;
  localparam int unsigned DCW = $clog2(QW);
  localparam int unsigned SH  = 32 - FRAC_BITS;
  localparam int unsigned NS  = 36;

  localparam logic [64:0] MAG_LIM = 65'd1 << 63;
  localparam logic [63:0] HI_LIM  = 64'd1 << (63 - SH);
  localparam logic [63:0] MAG_ONE = 64'd1 << 32;

  typedef enum logic [NS-1:0] {
    S_LOAD     = NS'(1) << 0,
    S_INIT     = NS'(1) << 1,
    S_PS_RD    = NS'(1) << 2,
    S_PS_CMP   = NS'(1) << 3,
    S_PS_CHK   = NS'(1) << 4,
    S_DET_HI   = NS'(1) << 5,
    S_DET_LO   = NS'(1) << 6,
    S_DET_FIN  = NS'(1) << 7,
    S_EL_ROW   = NS'(1) << 8,
    S_EL_RD    = NS'(1) << 9,
    S_EL_DV    = NS'(1) << 10,
    S_DIV      = NS'(1) << 11,
    S_EL_WM    = NS'(1) << 12,
    S_EL_RU    = NS'(1) << 13,
    S_EL_RA    = NS'(1) << 14,
    S_EL_MUL   = NS'(1) << 15,
    S_EL_SUB   = NS'(1) << 16,
    S_EL_NEXT  = NS'(1) << 17,
    S_FW_INIT  = NS'(1) << 18,
    S_FW_ACC0  = NS'(1) << 19,
    S_FW_RD    = NS'(1) << 20,
    S_FW_MUL   = NS'(1) << 21,
    S_FW_SUB   = NS'(1) << 22,
    S_FW_WR    = NS'(1) << 23,
    S_BK_INIT  = NS'(1) << 24,
    S_BK_ACC0  = NS'(1) << 25,
    S_BK_RD    = NS'(1) << 26,
    S_BK_MUL   = NS'(1) << 27,
    S_BK_SUB   = NS'(1) << 28,
    S_BK_DRD   = NS'(1) << 29,
    S_BK_DV    = NS'(1) << 30,
    S_BK_WR    = NS'(1) << 31,
    S_FIN      = NS'(1) << 32,
    S_OUT_RD   = NS'(1) << 33,
    S_OUT_LD   = NS'(1) << 34,
    S_OUT_HOLD = NS'(1) << 35
  } state_e;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_ORDER) + AW'(c);
  endfunction

  // memories
  logic [31:0] mat_mem [MAX_ORDER*MAX_ORDER];
  logic [31:0] rhs_mem [MAX_ORDER];
  logic [31:0] vec_mem [MAX_ORDER];
  logic signed [31:0] mat_rd_q, rhs_rd_q, vec_rd_q;

  // control state
  state_e state_q, state_d, dv_ret_q;
  logic [lups_pkg::SIZE_W-1:0] size_q;
  logic [lups_pkg::THR_W-1:0]  thr_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] n_q, i_q, j_q, c_q, p_q;
  logic [IW-1:0] perm_q [MAX_ORDER];
  logic          out_valid_q;

  // datapath
  logic [31:0]        best_q;
  logic signed [31:0] piv_q, m_q, u_q, a_q;
  logic [IW-1:0]      pp_q, pj_q;
  logic signed [63:0] prod_q, acc_q;
  logic [63:0]        mag_q, dhi_q, dlo_q, det_q;
  logic               sing_q, sat_q, detsat_q, neg_q, par_q;
  logic [lups_pkg::STAT_W-1:0] stat_q;
  logic [31:0]        dv_rem_q, dv_den_q;
  logic [QW-1:0]      dv_quo_q;
  logic               dv_neg_q;
  logic [DCW-1:0]     dv_cnt_q;
  logic signed [31:0] xo_q;
  logic [lups_pkg::XIDX_W-1:0] xi_q;
  logic               xl_q;

  // load addressing
  logic [NW-1:0] n_cfg, ld_row;
  logic [CW-1:0] nn, total, cnt_eff, cnt_nx, ld_col;
  logic          ld_acc, ld_is_mat, ld_done;

  always_comb begin
    if (size_q == '0) begin
      n_cfg = NW'(1);
    end else if (32'(size_q) > MAX_ORDER) begin
      n_cfg = NW'(MAX_ORDER);
    end else begin
      n_cfg = NW'(size_q);
    end
  end

  assign nn      = CW'(n_cfg) * CW'(n_cfg);
  assign total   = nn + CW'(n_cfg);
  assign cnt_eff = (cnt_q >= total) ? '0 : cnt_q;
  assign cnt_nx  = cnt_eff + CW'(1);
  assign ld_done = (cnt_nx == total);
  assign ld_is_mat = (cnt_eff < nn);
  assign ld_acc  = (state_q == S_LOAD) && elem_i.valid;

  always_comb begin
    ld_row = '0;
    for (int k = 1; k < MAX_ORDER; k++) begin
      if (CW'(k) * CW'(n_cfg) <= cnt_eff) ld_row = NW'(k);
    end
  end
  assign ld_col = cnt_eff - CW'(ld_row) * CW'(n_cfg);

  // shared address and arithmetic
  logic [NW-1:0] lrow, mcol, vaddr;
  logic [IW-1:0] perm_rd;
  logic [AW-1:0] mat_raddr;
  logic          mat_we;
  logic [AW-1:0] mat_waddr;
  logic [31:0]   mat_wdata;
  logic [31:0]   a_abs;
  logic          pick;
  lups_pkg::sat32_t acc_sat, sub_sat, dres;
  logic [32:0]   rem_sh;
  logic          rem_ge;
  logic [31:0]   dv_num;
  logic [31:0]   dv_den_src;
  logic [64:0]   mag_r;
  logic          neg_f;

  assign lrow    = (state_q == S_EL_RU) ? j_q : i_q;
  assign perm_rd = perm_q[lrow[IW-1:0]];

  always_comb begin
    case (state_q)
      S_PS_RD, S_EL_RD: mcol = j_q;
      S_BK_DRD:         mcol = i_q;
      default:          mcol = c_q;
    endcase
  end
  assign mat_raddr = maddr(perm_rd, mcol[IW-1:0]);
  assign vaddr     = ((state_q == S_BK_INIT) || (state_q == S_OUT_RD)) ? i_q : c_q;

  assign a_abs   = lups_pkg::abs32(mat_rd_q);
  assign pick    = (i_q == j_q) || (a_abs > best_q);
  assign acc_sat = lups_pkg::sat32(acc_q);
  assign sub_sat = lups_pkg::sat32(64'(a_q) - (prod_q >>> FRAC_BITS));

  always_comb begin
    dres.sat = 1'b0;
    dres.val = dv_quo_q[31:0];
    if (dv_neg_q) begin
      if (dv_quo_q > QW'(64'h8000_0000)) begin
        dres.sat = 1'b1;
        dres.val = 32'h8000_0000;
      end else begin
        dres.val = ~dv_quo_q[31:0] + 32'd1;
      end
    end else if (dv_quo_q > QW'(64'h7fff_ffff)) begin
      dres.sat = 1'b1;
      dres.val = 32'h7fff_ffff;
    end
  end

  assign rem_sh     = {dv_rem_q, dv_quo_q[QW-1]};
  assign rem_ge     = (rem_sh >= {1'b0, dv_den_q});
  assign dv_num     = (state_q == S_BK_DV) ? acc_sat.val : mat_rd_q;
  assign dv_den_src = (state_q == S_BK_DV) ? mat_rd_q : piv_q;
  assign mag_r      = {1'b0, dhi_q << SH} + 65'(dlo_q >> FRAC_BITS);
  assign neg_f      = neg_q ^ par_q;

  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = '0;
    mat_wdata = elem_i.elem_value;
    if (ld_acc && ld_is_mat) begin
      mat_we    = 1'b1;
      mat_waddr = maddr(ld_row[IW-1:0], ld_col[IW-1:0]);
    end else if (state_q == S_EL_WM) begin
      mat_we    = 1'b1;
      mat_waddr = maddr(perm_rd, j_q[IW-1:0]);
      mat_wdata = dres.val;
    end else if (state_q == S_EL_SUB) begin
      mat_we    = 1'b1;
      mat_waddr = maddr(perm_rd, c_q[IW-1:0]);
      mat_wdata = sub_sat.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
    mat_rd_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_acc && !ld_is_mat) rhs_mem[IW'(cnt_eff - nn)] <= elem_i.elem_value;
    rhs_rd_q <= rhs_mem[perm_rd];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FW_WR) vec_mem[i_q[IW-1:0]] <= acc_sat.val;
    else if (state_q == S_BK_WR) vec_mem[i_q[IW-1:0]] <= dres.val;
    vec_rd_q <= vec_mem[vaddr[IW-1:0]];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:    if (ld_acc && ld_done) state_d = S_INIT;
      S_INIT:    state_d = S_PS_RD;
      S_PS_RD:   state_d = S_PS_CMP;
      S_PS_CMP:  state_d = ((i_q + NW'(1)) == n_q) ? S_PS_CHK : S_PS_RD;
      S_PS_CHK:  state_d = ((best_q == '0) || (best_q < 32'(thr_q))) ? S_FIN : S_DET_HI;
      S_DET_HI:  state_d = S_DET_LO;
      S_DET_LO:  state_d = S_DET_FIN;
      S_DET_FIN: state_d = S_EL_ROW;
      S_EL_ROW: begin
        if (i_q == n_q) state_d = ((j_q + NW'(1)) == n_q) ? S_FW_INIT : S_PS_RD;
        else state_d = S_EL_RD;
      end
      S_EL_RD:   state_d = S_EL_DV;
      S_EL_DV:   state_d = S_DIV;
      S_DIV:     if (dv_cnt_q == DCW'(QW - 1)) state_d = dv_ret_q;
      S_EL_WM:   state_d = ((j_q + NW'(1)) == n_q) ? S_EL_NEXT : S_EL_RU;
      S_EL_RU:   state_d = S_EL_RA;
      S_EL_RA:   state_d = S_EL_MUL;
      S_EL_MUL:  state_d = S_EL_SUB;
      S_EL_SUB:  state_d = ((c_q + NW'(1)) == n_q) ? S_EL_NEXT : S_EL_RU;
      S_EL_NEXT: state_d = S_EL_ROW;
      S_FW_INIT: state_d = S_FW_ACC0;
      S_FW_ACC0: state_d = (i_q == '0) ? S_FW_WR : S_FW_RD;
      S_FW_RD:   state_d = S_FW_MUL;
      S_FW_MUL:  state_d = S_FW_SUB;
      S_FW_SUB:  state_d = ((c_q + NW'(1)) == i_q) ? S_FW_WR : S_FW_RD;
      S_FW_WR:   state_d = ((i_q + NW'(1)) == n_q) ? S_BK_INIT : S_FW_INIT;
      S_BK_INIT: state_d = S_BK_ACC0;
      S_BK_ACC0: state_d = ((i_q + NW'(1)) == n_q) ? S_BK_DRD : S_BK_RD;
      S_BK_RD:   state_d = S_BK_MUL;
      S_BK_MUL:  state_d = S_BK_SUB;
      S_BK_SUB:  state_d = ((c_q + NW'(1)) == n_q) ? S_BK_DRD : S_BK_RD;
      S_BK_DRD:  state_d = S_BK_DV;
      S_BK_DV:   state_d = S_DIV;
      S_BK_WR:   state_d = (i_q == '0) ? S_FIN : S_BK_INIT;
      S_FIN:     state_d = S_OUT_RD;
      S_OUT_RD:  state_d = S_OUT_LD;
      S_OUT_LD:  state_d = S_OUT_HOLD;
      S_OUT_HOLD: begin
        if (result_o.ready) state_d = ((i_q + NW'(1)) == n_q) ? S_LOAD : S_OUT_RD;
      end
      default:   state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      size_q      <= lups_pkg::SIZE_RESET;
      thr_q       <= lups_pkg::THR_RESET;
      cnt_q       <= '0;
      n_q         <= NW'(MAX_ORDER);
      i_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) perm_q[k] <= IW'(k);
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == lups_pkg::REG_MATRIX_SIZE) size_q <= cfg_i.data[lups_pkg::SIZE_W-1:0];
        if (cfg_i.index == lups_pkg::REG_PIVOT_THRESHOLD) thr_q <= cfg_i.data[lups_pkg::THR_W-1:0];
      end
      case (state_q)
        S_LOAD: begin
          if (ld_acc) begin
            cnt_q <= ld_done ? '0 : cnt_nx;
            if (ld_done) n_q <= n_cfg;
          end
        end
        S_INIT: begin
          for (int k = 0; k < MAX_ORDER; k++) perm_q[k] <= IW'(k);
          i_q <= '0;
          j_q <= '0;
        end
        S_PS_CMP: begin
          if (pick) p_q <= i_q;
          if ((i_q + NW'(1)) != n_q) i_q <= i_q + NW'(1);
        end
        S_PS_CHK: begin
          if (p_q != j_q) begin
            perm_q[j_q[IW-1:0]] <= pp_q;
            perm_q[p_q[IW-1:0]] <= pj_q;
          end
        end
        S_DET_FIN: i_q <= j_q + NW'(1);
        S_EL_ROW: begin
          if (i_q == n_q) begin
            if ((j_q + NW'(1)) == n_q) begin
              i_q <= '0;
            end else begin
              j_q <= j_q + NW'(1);
              i_q <= j_q + NW'(1);
            end
          end
        end
        S_EL_WM:   c_q <= j_q + NW'(1);
        S_EL_SUB:  c_q <= c_q + NW'(1);
        S_EL_NEXT: i_q <= i_q + NW'(1);
        S_FW_ACC0: c_q <= '0;
        S_FW_SUB:  c_q <= c_q + NW'(1);
        S_FW_WR:   i_q <= ((i_q + NW'(1)) == n_q) ? i_q : i_q + NW'(1);
        S_BK_ACC0: c_q <= i_q + NW'(1);
        S_BK_SUB:  c_q <= c_q + NW'(1);
        S_BK_WR:   if (i_q != '0) i_q <= i_q - NW'(1);
        S_FIN:     i_q <= '0;
        S_OUT_LD:  out_valid_q <= 1'b1;
        S_OUT_HOLD: begin
          if (result_o.ready) begin
            out_valid_q <= 1'b0;
            if ((i_q + NW'(1)) != n_q) i_q <= i_q + NW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_INIT: begin
        par_q    <= 1'b0;
        neg_q    <= 1'b0;
        sat_q    <= 1'b0;
        detsat_q <= 1'b0;
        sing_q   <= 1'b0;
        mag_q    <= MAG_ONE;
      end
      S_PS_CMP: begin
        if (pick) begin
          best_q <= a_abs;
          piv_q  <= mat_rd_q;
          pp_q   <= perm_rd;
        end
        if (i_q == j_q) pj_q <= perm_rd;
      end
      S_PS_CHK: begin
        if ((best_q == '0) || (best_q < 32'(thr_q))) begin
          sing_q <= 1'b1;
        end else begin
          if (p_q != j_q) par_q <= ~par_q;
          if (piv_q[31]) neg_q <= ~neg_q;
        end
      end
      S_DET_HI: dlo_q <= mag_q[63:32] * best_q;
      S_DET_LO: begin
        dhi_q <= dlo_q;
        dlo_q <= mag_q[31:0] * best_q;
      end
      S_DET_FIN: begin
        if (!detsat_q) begin
          if ((dhi_q > HI_LIM) || (mag_r > MAG_LIM)) begin
            detsat_q <= 1'b1;
            mag_q    <= MAG_LIM[63:0];
          end else begin
            mag_q <= mag_r[63:0];
          end
        end
      end
      S_EL_DV, S_BK_DV: begin
        dv_quo_q <= {lups_pkg::abs32(dv_num), FRAC_BITS'(0)};
        dv_den_q <= lups_pkg::abs32(dv_den_src);
        dv_neg_q <= dv_num[31] ^ dv_den_src[31];
        dv_rem_q <= '0;
        dv_cnt_q <= '0;
        dv_ret_q <= (state_q == S_BK_DV) ? S_BK_WR : S_EL_WM;
        if (state_q == S_BK_DV && acc_sat.sat) sat_q <= 1'b1;
      end
      S_DIV: begin
        dv_rem_q <= rem_ge ? 32'(rem_sh - {1'b0, dv_den_q}) : rem_sh[31:0];
        dv_quo_q <= {dv_quo_q[QW-2:0], rem_ge};
        dv_cnt_q <= dv_cnt_q + DCW'(1);
      end
      S_EL_WM: begin
        m_q <= dres.val;
        if (dres.sat) sat_q <= 1'b1;
      end
      S_EL_RA: u_q <= mat_rd_q;
      S_EL_MUL: begin
        a_q    <= mat_rd_q;
        prod_q <= m_q * u_q;
      end
      S_EL_SUB: if (sub_sat.sat) sat_q <= 1'b1;
      S_FW_ACC0: acc_q <= 64'(rhs_rd_q);
      S_BK_ACC0: acc_q <= 64'(vec_rd_q);
      S_FW_MUL, S_BK_MUL: prod_q <= mat_rd_q * vec_rd_q;
      S_FW_SUB, S_BK_SUB: acc_q <= acc_q - (prod_q >>> FRAC_BITS);
      S_FW_WR: if (acc_sat.sat) sat_q <= 1'b1;
      S_BK_WR: if (dres.sat) sat_q <= 1'b1;
      S_FIN: begin
        if (sing_q) begin
          det_q  <= '0;
          stat_q <= lups_pkg::STAT_SINGULAR;
        end else if (neg_f) begin
          det_q  <= 64'd0 - mag_q;
          stat_q <= (sat_q || detsat_q) ? lups_pkg::STAT_SAT : lups_pkg::STAT_OK;
        end else if (mag_q[63]) begin
          det_q  <= 64'h7fff_ffff_ffff_ffff;
          stat_q <= lups_pkg::STAT_SAT;
        end else begin
          det_q  <= mag_q;
          stat_q <= (sat_q || detsat_q) ? lups_pkg::STAT_SAT : lups_pkg::STAT_OK;
        end
      end
      S_OUT_LD: begin
        xo_q <= sing_q ? '0 : vec_rd_q;
        xi_q <= lups_pkg::XIDX_W'(i_q);
        xl_q <= ((i_q + NW'(1)) == n_q);
      end
      default: ;
    endcase
  end

  assign elem_i.ready = (state_q == S_LOAD);
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid       = out_valid_q;
  assign result_o.x_value     = xo_q;
  assign result_o.x_index     = xi_q;
  assign result_o.last        = xl_q;
  assign result_o.status      = stat_q;
  assign result_o.determinant = det_q;

`ifndef SYNTHESIS
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_i.ready |-> !result_o.valid)
    else $error("element request taken while a result is pending");

  a_last_reopens_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.last) |=> elem_i.ready)
    else $error("load not reopened after last result");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(state_q == S_OUT_LD))
    else $error("result valid raised outside of result load");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dv_cnt_q <= DCW'(QW - 1)))
    else $error("divider ran past its width");
`endif

endmodule
`default_nettype wire
